// File: hdl/afm_pkg.sv
// shared constants, types and control/status bundles of the frequency meter
`default_nettype none

package afm_pkg;

    // measurement shape
    localparam int CAPTURE_COUNT = 12;
    localparam int DISCARD_COUNT = 2;
    localparam int COUNTER_BITS  = 16;
    localparam int KEPT_COUNT    = (CAPTURE_COUNT > DISCARD_COUNT) ?
                                   (CAPTURE_COUNT - DISCARD_COUNT) : 0;

    // field widths
    localparam int RATE_BITS  = 27;
    localparam int FREQ_BITS  = 30;
    localparam int INDEX_BITS = 4;
    localparam int SUM_BITS   = COUNTER_BITS + 4;
    localparam int NUM_BITS   = RATE_BITS + 4;
    localparam int STEP_BITS  = $clog2(NUM_BITS);

    localparam logic [RATE_BITS-1:0]    RATE_RESET  = RATE_BITS'(2000000);
    localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [FREQ_BITS-1:0]    FREQ_MAX    = {FREQ_BITS{1'b1}};

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_NO_PERIOD = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic busy;
        logic emit_ovf;
        logic emit_zero;
        logic load_div;
        logic div_step;
        logic emit_quot;
    } afm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic ovf;
        logic last_cap;
        logic sum_zero;
        logic div_last;
        logic out_free;
    } afm_stat_t;

endpackage

`default_nettype wire

// File: hdl/averaged_period_frequency_meter.sv
// top level of the averaged-period frequency meter
`default_nettype none

// Reciprocal frequency counter. Each input request is one prescaled timer tick
// carrying a start flag, a probe select and the falling-edge flags of both
// probes; while counting and with room at the output the block takes one
// request per clock. A start clears the measurement; edges on the selected probe
// close periods, the first two are dropped and the next ten summed, and after
// the twelfth the block reports floor(10 * tick_rate_hz / sum), saturated to 30
// bits. A counter overflow gives status 1 and a zero sum status 2, both in the
// tick that causes them. The closing restoring divider scales the tick rate,
// gives one quotient bit per divide step and writes the result; s_axis_tready
// is low from the final capture until that write. The user writes tick_rate_hz
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module averaged_period_frequency_meter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [26:0] cfg_wr_data,
    // tick stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // start_req, probe_select, edge_probe0,
                                             // edge_probe1, zero fill
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // frequency_hz[29:0], probe_measured, zero fill
    output logic [1:0]       m_axis_tuser    // status
);
    import afm_pkg::*;

    afm_cmd_t             cmd;
    afm_stat_t            st;
    logic [FREQ_BITS-1:0] out_freq;
    status_t              out_status;
    logic                 out_probe;

    // sequencing
    afm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // counting, summing, dividing
    afm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_start    (s_axis_tdata[0]),
        .in_select   (s_axis_tdata[1]),
        .in_edge0    (s_axis_tdata[2]),
        .in_edge1    (s_axis_tdata[3]),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_freq    (out_freq),
        .out_status  (out_status),
        .out_probe   (out_probe)
    );

    // result packing
    assign m_axis_tdata = {1'b0, out_probe, out_freq};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// File: hdl/afm_ctrl.sv
// controller state machine of the frequency meter
`default_nettype none

module afm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire afm_pkg::afm_stat_t st,
    output afm_pkg::afm_cmd_t      cmd
);
    import afm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // input requests are taken while idle or counting and with room at the output
    assign in_ready = ((state_reg == ST_IDLE) || (state_reg == ST_RUN)) && st.out_free;
    assign accept   = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && st.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (st.start)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (st.ovf)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (st.last_cap)
                    begin
                        state_next = st.sum_zero ? ST_IDLE : ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.busy      = (state_reg == ST_RUN);
        case (state_reg)
            ST_RUN:
            begin
                cmd.emit_ovf  = accept && !st.start && st.ovf;
                cmd.emit_zero = accept && !st.start && !st.ovf && st.last_cap && st.sum_zero;
            end
            ST_LOAD:
            begin
                cmd.load_div = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit_quot = st.out_free;
            end
            default:
            begin
            end
        endcase
    end

    // scaling is always followed by the divide
    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> state_reg == ST_DIV)
        else $error("divide did not follow numerator load");

    // no request is taken while the divider owns the datapath
    a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_div || cmd.div_step || state_reg == ST_DONE) |-> !accept)
        else $error("request accepted during divide");

    // a final capture with a nonzero sum always starts the divide
    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && accept && !st.start && !st.ovf && st.last_cap
         && !st.sum_zero) |=> state_reg == ST_LOAD)
        else $error("final capture did not start the divide");

endmodule

`default_nettype wire

// File: hdl/afm_datapath.sv
// counter, period accumulator, divider and result register of the frequency meter
`default_nettype none

module afm_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [afm_pkg::RATE_BITS-1:0]      cfg_wr_data,
    input  wire logic                               in_start,
    input  wire logic                               in_select,
    input  wire logic                               in_edge0,
    input  wire logic                               in_edge1,
    input  wire afm_pkg::afm_cmd_t                  cmd,
    output afm_pkg::afm_stat_t                      st,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [afm_pkg::FREQ_BITS-1:0]           out_freq,
    output afm_pkg::status_t                        out_status,
    output logic                                    out_probe
);
    import afm_pkg::*;

    logic [RATE_BITS-1:0]    rate_reg;
    logic [COUNTER_BITS-1:0] counter_reg;
    logic [COUNTER_BITS-1:0] counter_inc;
    logic [INDEX_BITS-1:0]   index_reg;
    logic [INDEX_BITS-1:0]   index_inc;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [SUM_BITS-1:0]     sum_next;
    logic                    probe_reg;
    logic                    edge_sel;
    logic                    capture;

    logic [NUM_BITS-1:0]     num_reg;
    logic [SUM_BITS:0]       rem_reg;
    logic [SUM_BITS:0]       rem_shift;
    logic                    rem_ge;
    logic [STEP_BITS-1:0]    step_reg;

    logic                    out_valid_reg;
    logic [FREQ_BITS-1:0]    freq_reg;
    status_t                 status_reg;
    logic                    oprobe_reg;

    // tick bookkeeping
    assign counter_inc = counter_reg + 1'b1;
    assign index_inc   = index_reg + 1'b1;
    assign edge_sel    = probe_reg ? in_edge1 : in_edge0;
    assign capture     = edge_sel && (counter_reg != COUNTER_MAX);
    assign sum_next    = (index_reg >= INDEX_BITS'(DISCARD_COUNT)) ?
                         (sum_reg + SUM_BITS'(counter_inc)) : sum_reg;

    // status toward the controller
    assign st.start    = in_start;
    assign st.ovf      = (counter_reg == COUNTER_MAX);
    assign st.last_cap = edge_sel && (index_inc == INDEX_BITS'(CAPTURE_COUNT));
    assign st.sum_zero = (sum_next == '0);
    assign st.div_last = (step_reg == STEP_BITS'(NUM_BITS - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    // rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            rate_reg <= cfg_wr_data;
        end
    end

    // period counter, capture index and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            index_reg   <= '0;
            sum_reg     <= '0;
            probe_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (in_start)
            begin
                counter_reg <= '0;
                index_reg   <= '0;
                sum_reg     <= '0;
                probe_reg   <= in_select;
            end
            else if (cmd.busy)
            begin
                if (st.ovf)
                begin
                    counter_reg <= '0;
                end
                else if (capture)
                begin
                    counter_reg <= '0;
                    sum_reg     <= sum_next;
                    index_reg   <= index_inc;
                end
                else
                begin
                    counter_reg <= counter_inc;
                end
            end
        end
    end

    // restoring divider step, one quotient bit a cycle
    assign rem_shift = {rem_reg[SUM_BITS-1:0], num_reg[NUM_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, sum_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            num_reg  <= NUM_BITS'(rate_reg) * NUM_BITS'(KEPT_COUNT);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[NUM_BITS-2:0], rem_ge};
            rem_reg  <= rem_ge ? (rem_shift - {1'b0, sum_reg}) : rem_shift;
            step_reg <= step_reg + 1'b1;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ovf || cmd.emit_zero || cmd.emit_quot)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, quotient saturated to the field width
    always_ff @(posedge clk)
    begin
        if (cmd.emit_ovf)
        begin
            freq_reg   <= '0;
            status_reg <= STATUS_OVERFLOW;
            oprobe_reg <= probe_reg;
        end
        else if (cmd.emit_zero)
        begin
            freq_reg   <= '0;
            status_reg <= STATUS_NO_PERIOD;
            oprobe_reg <= probe_reg;
        end
        else if (cmd.emit_quot)
        begin
            freq_reg   <= (num_reg > NUM_BITS'(FREQ_MAX)) ? FREQ_MAX : num_reg[FREQ_BITS-1:0];
            status_reg <= STATUS_OK;
            oprobe_reg <= probe_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_freq   = freq_reg;
    assign out_status = status_reg;
    assign out_probe  = oprobe_reg;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < {1'b0, sum_reg}))
        else $error("divider remainder out of range");

    // the capture index never reaches the final count while busy
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.busy |-> (index_reg < INDEX_BITS'(CAPTURE_COUNT)))
        else $error("capture index past final count while busy");

endmodule

`default_nettype wire
